// ----- src/rmf_pkg.sv -----
// Shared types and constants for the running median finder.
package rmf_pkg;

    localparam int DEPTH   = 256;
    localparam int VALUE_W = 32;
    localparam int IN_W    = 32;
    localparam int MED_W   = 33;
    localparam int STCNT_W = 9;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int GRP     = 16;
    localparam int NGRP    = (DEPTH + GRP - 1) / GRP;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic signed [MED_W-1:0]   t_median;
    typedef logic [CNT_W-1:0]          t_count;

    typedef struct packed {
        logic ins;
        logic occ;
        logic at_end;
        logic sel_lo;
        logic sel_hi;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GATHER,
        ST_SUM,
        ST_HOLD
    } t_state;

endpackage

// ----- src/rmf_cell.sv -----
// One sorted cell: holds a value, compares against the new sample, shifts up on insert.
module rmf_cell (
    input  logic               i_clk,
    input  rmf_pkg::t_cell_ctl i_ctl,
    input  rmf_pkg::t_value    i_value,
    input  rmf_pkg::t_value    i_prev_value,
    input  logic               i_prev_gt,
    output rmf_pkg::t_value    o_value,
    output logic               o_gt,
    output rmf_pkg::t_value    o_lo,
    output rmf_pkg::t_value    o_hi
);
    import rmf_pkg::*;

    t_value r_val;

    assign o_value = r_val;
    assign o_gt    = i_ctl.occ && (r_val > i_value);
    assign o_lo    = i_ctl.sel_lo ? r_val : '0;
    assign o_hi    = i_ctl.sel_hi ? r_val : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && (o_gt || i_ctl.at_end)) begin
            r_val <= i_prev_gt ? i_prev_value : i_value;
        end
    end

endmodule

// ----- src/rmf_group.sv -----
// Registered OR stage that collects the selected middle values of one group of cells.
module rmf_group (
    input  logic            i_clk,
    input  logic            i_load,
    input  rmf_pkg::t_value i_lo [0:rmf_pkg::GRP-1],
    input  rmf_pkg::t_value i_hi [0:rmf_pkg::GRP-1],
    output rmf_pkg::t_value o_lo,
    output rmf_pkg::t_value o_hi
);
    import rmf_pkg::*;

    t_value r_lo;
    t_value r_hi;
    t_value w_lo;
    t_value w_hi;

    always_comb begin
        w_lo = '0;
        w_hi = '0;
        for (int k = 0; k < GRP; k++) begin
            w_lo = w_lo | i_lo[k];
            w_hi = w_hi | i_hi[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_lo <= w_lo;
            r_hi <= w_hi;
        end
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;

endmodule

// ----- src/running_median_finder.sv -----
// Top level of the running median finder: sorted cell chain, median readout, handshakes.
//
// Input channel (i_valid / o_ready) carries i_operation and i_value. An add beat
// inserts the low VALUE_W bits of i_value into a chain of DEPTH sorted cells:
// every cell compares in parallel and the larger ones shift up by one.
// Adds are taken one per cycle while no query is pending and produce no result
// beat. An add to a full chain is dropped and sets the sticky overflow flag.
// A query beat produces one result beat on the output channel (o_valid / i_ready):
// twice the median, the empty flag, the overflow flag and the count, all as they
// stood when the query was taken. The two middle cells are gathered through a
// registered two-level OR tree (group registers, then r_lo / r_hi) and summed
// into r_median, after which o_valid rises; the input side is held off until
// the result beat is taken.
// A stalled receiver keeps o_valid high with the result unchanged.
// Reset (i_rst_n low, synchronous) empties the chain and clears the overflow flag
// and any pending result; cell contents are not cleared since unused cells
// never affect a result.
module running_median_finder (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_operation,
    input  logic signed [rmf_pkg::IN_W-1:0]      i_value,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [rmf_pkg::MED_W-1:0]     o_median_doubled,
    output logic                                 o_empty_res,
    output logic                                 o_overflowed,
    output logic [rmf_pkg::STCNT_W-1:0]          o_stored_count
);
    import rmf_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_count  r_count;
    logic    r_ovf;
    t_count  r_q_count;
    logic    r_q_empty;
    logic    r_q_ovf;
    t_value  r_lo;
    t_value  r_hi;
    t_median r_median;

    logic    w_in_beat;
    logic    w_add;
    logic    w_query;
    logic    w_full;
    logic    w_ins;
    t_value  w_val;
    t_count  w_lo_idx;
    t_count  w_hi_idx;
    t_value  w_lo_all;
    t_value  w_hi_all;

    t_value  w_cell_val [0:DEPTH-1];
    logic    w_gt       [0:DEPTH-1];
    t_value  w_leaf_lo  [0:NGRP*GRP-1];
    t_value  w_leaf_hi  [0:NGRP*GRP-1];
    t_value  w_grp_lo   [0:NGRP-1];
    t_value  w_grp_hi   [0:NGRP-1];

    assign w_in_beat = i_valid && o_ready;
    assign w_add     = w_in_beat && (i_operation == OP_ADD);
    assign w_query   = w_in_beat && (i_operation == OP_QUERY);
    assign w_full    = (r_count == CNT_W'(DEPTH));
    assign w_ins     = w_add && !w_full;
    assign w_val     = t_value'(i_value[VALUE_W-1:0]);
    assign w_lo_idx  = (r_count - CNT_W'(1)) >> 1;
    assign w_hi_idx  = r_count >> 1;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_cell_ctl w_ctl;
        t_value    w_prev_val;
        logic      w_prev_gt;

        assign w_ctl.ins    = w_ins;
        assign w_ctl.occ    = CNT_W'(i) < r_count;
        assign w_ctl.at_end = CNT_W'(i) == r_count;
        assign w_ctl.sel_lo = CNT_W'(i) == w_lo_idx;
        assign w_ctl.sel_hi = CNT_W'(i) == w_hi_idx;

        if (i == 0) begin : g_first
            assign w_prev_val = '0;
            assign w_prev_gt  = 1'b0;
        end else begin : g_rest
            assign w_prev_val = w_cell_val[i-1];
            assign w_prev_gt  = w_gt[i-1];
        end

        rmf_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_value      (w_val),
            .i_prev_value (w_prev_val),
            .i_prev_gt    (w_prev_gt),
            .o_value      (w_cell_val[i]),
            .o_gt         (w_gt[i]),
            .o_lo         (w_leaf_lo[i]),
            .o_hi         (w_leaf_hi[i])
        );
    end

    for (genvar i = DEPTH; i < NGRP*GRP; i++) begin : g_pad
        assign w_leaf_lo[i] = '0;
        assign w_leaf_hi[i] = '0;
    end

    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        rmf_group u_group (
            .i_clk  (i_clk),
            .i_load (w_query),
            .i_lo   (w_leaf_lo[g*GRP : g*GRP+GRP-1]),
            .i_hi   (w_leaf_hi[g*GRP : g*GRP+GRP-1]),
            .o_lo   (w_grp_lo[g]),
            .o_hi   (w_grp_hi[g])
        );
    end

    always_comb begin
        w_lo_all = '0;
        w_hi_all = '0;
        for (int g = 0; g < NGRP; g++) begin
            w_lo_all = w_lo_all | w_grp_lo[g];
            w_hi_all = w_hi_all | w_grp_hi[g];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_query) begin
                    n_state = ST_GATHER;
                end
            end
            ST_GATHER: n_state = ST_SUM;
            ST_SUM:    n_state = ST_HOLD;
            ST_HOLD: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE:   o_ready = 1'b1;
            ST_HOLD:   o_valid = 1'b1;
            default: begin
                o_ready = 1'b0;
                o_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ins) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (w_add && w_full) begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_q_count <= r_count;
            r_q_empty <= (r_count == '0);
            r_q_ovf   <= r_ovf;
        end
        if (r_state == ST_GATHER) begin
            r_lo <= w_lo_all;
            r_hi <= w_hi_all;
        end
        if (r_state == ST_SUM) begin
            r_median <= r_q_empty ? '0 : (MED_W'(r_lo) + MED_W'(r_hi));
        end
    end

    assign o_median_doubled = r_median;
    assign o_empty_res      = r_q_empty;
    assign o_overflowed     = r_q_ovf;
    assign o_stored_count   = STCNT_W'(r_q_count);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("count exceeds depth");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not grow count");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("overflow flag dropped");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("input taken while result pending");
`endif

endmodule

// ----- bench/running_median_checker.sv -----
// Checker for the running median finder: watches both channels, predicts medians, compares.
module running_median_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_ready,
    input  logic                                 i_operation,
    input  logic signed [rmf_pkg::IN_W-1:0]      i_value,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_ready,
    input  logic signed [rmf_pkg::MED_W-1:0]     i_median_doubled,
    input  logic                                 i_empty_res,
    input  logic                                 i_overflowed,
    input  logic [rmf_pkg::STCNT_W-1:0]          i_stored_count,
    output int                                   o_fail_count,
    output int                                   o_pending
);

    import rmf_pkg::*;

    typedef struct {
        t_median            median_x2;
        logic               empty;
        logic               ovf;
        logic [STCNT_W-1:0] count;
    } t_median_beat;

    t_value       sorted_vals[$];
    logic         ovf_sticky;
    t_median_beat pending_medians[$];
    t_median_beat want;
    t_value       sample;
    int           pos;
    int           half;
    int           fails;

    initial begin
        ovf_sticky   = 1'b0;
        fails        = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic check_field(input string field, input logic signed [63:0] want_v,
                               input logic signed [63:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0d, got %0d", field, want_v, got_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sorted_vals.delete();
            pending_medians.delete();
            ovf_sticky = 1'b0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_medians.size() == 0) begin
                    $error("result beat with no query pending");
                    fails++;
                end else begin
                    want = pending_medians.pop_front();
                    check_field("median_doubled", want.median_x2, i_median_doubled);
                    check_field("empty_res", want.empty, i_empty_res);
                    check_field("overflowed", want.ovf, i_overflowed);
                    check_field("stored_count", want.count, i_stored_count);
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_operation == OP_ADD) begin
                    sample = t_value'(i_value[VALUE_W-1:0]);
                    if (sorted_vals.size() >= DEPTH) begin
                        ovf_sticky = 1'b1;
                    end else begin
                        // equal values stay ahead of the new one
                        pos = 0;
                        while (pos < sorted_vals.size() && sorted_vals[pos] <= sample)
                            pos++;
                        sorted_vals.insert(pos, sample);
                    end
                end else begin
                    want.empty     = (sorted_vals.size() == 0);
                    want.ovf       = ovf_sticky;
                    want.count     = STCNT_W'(sorted_vals.size());
                    want.median_x2 = '0;
                    half           = sorted_vals.size() / 2;
                    if (sorted_vals.size() % 2 == 1)
                        want.median_x2 = t_median'(sorted_vals[half])
                                       + t_median'(sorted_vals[half]);
                    else if (sorted_vals.size() != 0)
                        want.median_x2 = t_median'(sorted_vals[half-1])
                                       + t_median'(sorted_vals[half]);
                    pending_medians.push_back(want);
                end
            end
        end
        o_pending    <= pending_medians.size();
        o_fail_count <= fails;
    end

endmodule

// ----- bench/tb_running_median_finder.sv -----
// Testbench top for the running median finder: stimulus, receiver stalls, watchdog, verdict.
module tb_running_median_finder;

    import rmf_pkg::*;

    localparam int     RAND_ITEMS   = 1030;
    localparam int     IDLE_LIMIT   = 2000;
    localparam int     DRAIN_CYCLES = 8;
    localparam int     LONG_HOLD    = 400;
    localparam t_value VAL_MAX      = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam t_value VAL_MIN      = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_THIRD,
        RX_MOSTLY
    } t_rx_mode;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_valid     = 1'b0;
    logic                      i_operation = OP_ADD;
    logic signed [IN_W-1:0]    i_value     = '0;
    logic                      i_ready     = 1'b0;
    logic                      o_ready;
    logic                      o_valid;
    logic signed [MED_W-1:0]   o_median_doubled;
    logic                      o_empty_res;
    logic                      o_overflowed;
    logic [STCNT_W-1:0]        o_stored_count;
    int                        fail_count;
    int                        pending;

    int       burst_left     = 0;
    int       adds_sent      = 0;
    int       queries_sent   = 0;
    int       results_seen   = 0;
    int       hold_left      = 0;
    int       ready_phase    = 0;
    int       idle_cycles    = 0;
    logic     long_hold_done = 1'b0;
    t_rx_mode rx_mode        = RX_OPEN;

    running_median_finder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_operation      (i_operation),
        .i_value          (i_value),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_median_doubled (o_median_doubled),
        .o_empty_res      (o_empty_res),
        .o_overflowed     (o_overflowed),
        .o_stored_count   (o_stored_count)
    );

    running_median_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_operation      (i_operation),
        .i_value          (i_value),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_median_doubled (o_median_doubled),
        .i_empty_res      (o_empty_res),
        .i_overflowed     (o_overflowed),
        .i_stored_count   (o_stored_count),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_value rand_sample();
        int r;
        r = $urandom_range(0, 15);
        case ($urandom_range(0, 7))
            0, 1: return t_value'(r % 9 - 4);
            2: begin
                case (r % 4)
                    0: return VAL_MAX;
                    1: return VAL_MIN;
                    2: return t_value'(0);
                    default: return t_value'(-1);
                endcase
            end
            3: return (r < 8) ? VAL_MAX - t_value'(r) : VAL_MIN + t_value'(r);
            default: return t_value'($urandom);
        endcase
    endfunction

    task automatic push_beat(input logic op, input t_value v);
        int gap;
        i_operation <= op;
        i_value     <= v;
        i_valid     <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (op == OP_QUERY) queries_sent++;
        else adds_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = $urandom_range(1, 10);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 16);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // receiver: changing stall pattern, plus one long hold-off to back up the input
    always @(posedge i_clk) begin
        if (o_valid && i_ready) results_seen++;
        ready_phase++;
        if (ready_phase % 50 == 0) rx_mode = t_rx_mode'($urandom_range(0, 3));
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (!long_hold_done && results_seen >= 40) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
            i_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN:  i_ready <= 1'b1;
                RX_COIN:  i_ready <= 1'($urandom_range(0, 1));
                RX_THIRD: i_ready <= (ready_phase % 3 == 0);
                default:  i_ready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int   rand_sent;
        logic op;
        rand_sent = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_beat(OP_QUERY, t_value'($urandom));
        push_beat(OP_ADD, VAL_MAX);
        push_beat(OP_QUERY, t_value'($urandom));
        push_beat(OP_ADD, VAL_MAX);
        push_beat(OP_QUERY, t_value'($urandom));
        repeat (3) push_beat(OP_ADD, VAL_MIN);
        push_beat(OP_QUERY, t_value'($urandom));
        push_beat(OP_ADD, VAL_MIN);
        push_beat(OP_QUERY, t_value'($urandom));
        push_beat(OP_ADD, t_value'(0));
        push_beat(OP_ADD, t_value'(-1));
        push_beat(OP_QUERY, t_value'($urandom));
        repeat (3) push_beat(OP_ADD, t_value'(5));
        push_beat(OP_QUERY, t_value'($urandom));
        push_beat(OP_ADD, 32'sh5555_5555);
        push_beat(OP_ADD, 32'shAAAA_AAAA);
        push_beat(OP_QUERY, t_value'($urandom));

        // enough adds in the mix to fill the store, so the late ones are dropped
        while (rand_sent < RAND_ITEMS) begin
            op = ($urandom_range(0, 99) < 35) ? OP_ADD : OP_QUERY;
            rand_sent++;
            push_beat(op, rand_sample());
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d adds (%0d past a full store) and %0d queries; %0d medians checked",
                 adds_sent, (adds_sent > DEPTH) ? adds_sent - DEPTH : 0,
                 queries_sent, results_seen);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/rmf_pkg.sv
src/rmf_cell.sv
src/rmf_group.sv
src/running_median_finder.sv
bench/running_median_checker.sv
bench/tb_running_median_finder.sv
